// ===== src/assert_macros.svh =====
// Assertion macros shared by the open-handle table RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is high.
`define OHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OHT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/oht_pkg.sv =====
// Types and constants for the open-handle table.
// No dependencies; used by open_handle_table and oht_handle_ram.
package oht_pkg;

   localparam int HANDLE_W = 32;
   localparam int SLOT_OUT_W = 4;

   localparam logic [1:0] CMD_OPEN   = 2'd0;
   localparam logic [1:0] CMD_CLOSE  = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [HANDLE_W-1:0] HANDLE_FIRST = 32'd1;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [HANDLE_W-1:0] req_handle;
   } req_beat_type;

   typedef struct packed {
      logic                  ok;
      logic [HANDLE_W-1:0]   out_handle;
      logic [SLOT_OUT_W-1:0] slot_index;
   } rsp_beat_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== src/oht_handle_ram.sv =====
// Handle store: one write port, one read port, registered read data.
// Depends on oht_pkg for the handle width.
module oht_handle_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [oht_pkg::HANDLE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [oht_pkg::HANDLE_W-1:0]  rd_data
);

   logic [oht_pkg::HANDLE_W-1:0] mem [DEPTH];
   logic [oht_pkg::HANDLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/open_handle_table.sv =====
// Open-handle table top level: command sequencer, valid bits, handle counter.
// Depends on oht_pkg, oht_handle_ram and assert_macros.svh.
//
// Usage
//   Request channel: drive req_beat and raise start while busy is low; the
//   beat is taken at that clock edge. cmd OPEN claims the lowest free slot
//   and hands it the running handle counter (starts at 1, skips 0 on wrap).
//   CLOSE frees the lowest valid slot holding req_handle; LOOKUP reports it.
//   Any other cmd code fails with no state change.
//   Response channel: every request yields one response beat, held on
//   rsp_beat for exactly one cycle with rsp_strobe high. The receiver has
//   no way to stall it and must take it in that cycle.
//   The slots are walked one per cycle, lowest first. OPEN strobes its
//   response once the walk reaches a free slot; CLOSE/LOOKUP compare a
//   slot once the handle memory's registered read of it returns, so each
//   compare trails its read. A miss or full table takes the whole walk.
//   Throughput is one request per walk; busy drops in the cycle the
//   response is strobed, so the next request may be taken at the edge
//   that ends that cycle.
//   Reset: synchronous, active high. All slots become free and the counter
//   returns to 1. The handle memory keeps its contents; a slot's handle is
//   only compared while its valid bit is set.
module open_handle_table #(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  oht_pkg::req_beat_type req_beat,
   output logic                  rsp_strobe,
   output oht_pkg::rsp_beat_type rsp_beat
);

`include "assert_macros.svh"

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int HW    = oht_pkg::HANDLE_W;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   // sequencer state
   oht_pkg::state_type state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [HW-1:0]      key_ff, key_in;      // handle being searched for
   logic [CNT_W-1:0]   scan_ff, scan_in;    // next slot to visit / read
   logic               chk_vld_ff, chk_vld_in;  // read data in flight
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;  // slot of that read data

   // table state
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [HW-1:0]      counter_ff, counter_in;

   // response registers
   logic               strobe_ff, strobe_in;
   oht_pkg::rsp_beat_type rsp_ff, rsp_in;

   // memory port signals
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [HW-1:0]      wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [HW-1:0]      rd_data;

   logic               done;
   logic               accept;
   logic [IDX_W-1:0]   scan_idx;
   logic               is_open;
   logic               is_find;
   logic               hit;

   assign accept   = start && (state_ff == oht_pkg::ST_IDLE);
   assign scan_idx = scan_ff[IDX_W-1:0];
   assign is_open  = (cmd_ff == oht_pkg::CMD_OPEN);
   assign is_find  = (cmd_ff == oht_pkg::CMD_CLOSE) || (cmd_ff == oht_pkg::CMD_LOOKUP);
   assign hit      = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_data == key_ff);

   oht_handle_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oht_pkg::ST_IDLE: begin
            if (start) begin
               state_in = oht_pkg::ST_SCAN;
            end
         end
         oht_pkg::ST_SCAN: begin
            if (done) begin
               state_in = oht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = oht_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      valid_in   = valid_ff;
      counter_in = counter_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = scan_idx;
      wr_data    = counter_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_idx;
      done       = 1'b0;

      case (state_ff)
         oht_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_beat.cmd;
               key_in  = req_beat.req_handle;
               scan_in = '0;
            end
         end
         oht_pkg::ST_SCAN: begin
            // ok only rises on a found slot; never carried over from the last beat
            rsp_in.ok = 1'b0;
            if (is_open) begin
               // one valid bit per cycle, lowest slot first
               if (!valid_ff[scan_idx]) begin
                  done                = 1'b1;
                  wr_en               = 1'b1;
                  valid_in[scan_idx]  = 1'b1;
                  rsp_in.ok           = 1'b1;
                  rsp_in.out_handle   = counter_ff;
                  rsp_in.slot_index   = oht_pkg::SLOT_OUT_W'(scan_idx);
                  counter_in = (counter_ff == '1) ? oht_pkg::HANDLE_FIRST
                                                  : counter_ff + HW'(1);
               end else if (scan_ff == LAST_CNT) begin
                  done = 1'b1;
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end else if (is_find) begin
               // read slot n while comparing slot n-1
               if (scan_ff < SLOTS_CNT) begin
                  rd_en      = 1'b1;
                  chk_vld_in = 1'b1;
                  chk_idx_in = scan_idx;
                  scan_in    = scan_ff + CNT_W'(1);
               end
               if (hit) begin
                  done              = 1'b1;
                  rsp_in.ok         = 1'b1;
                  rsp_in.out_handle = rd_data;
                  rsp_in.slot_index = oht_pkg::SLOT_OUT_W'(chk_idx_ff);
                  if (cmd_ff == oht_pkg::CMD_CLOSE) begin
                     valid_in[chk_idx_ff] = 1'b0;
                  end
               end else if (chk_vld_ff && (chk_idx_ff == LAST_IDX)) begin
                  done = 1'b1;
               end
            end else begin
               done = 1'b1;
            end

            if (done) begin
               strobe_in  = 1'b1;
               chk_vld_in = 1'b0;
               if (!rsp_in.ok) begin
                  rsp_in.out_handle = '0;
                  rsp_in.slot_index = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= oht_pkg::ST_IDLE;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
         counter_ff <= oht_pkg::HANDLE_FIRST;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
         counter_ff <= counter_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != oht_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_beat   = rsp_ff;

   `OHT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
   `OHT_ASSERT(a_strobe_after_scan, rsp_strobe |-> $past(busy), "response without a request in flight")
   `OHT_ASSERT(a_fail_zero, rsp_strobe && !rsp_beat.ok |-> (rsp_beat.out_handle == '0) && (rsp_beat.slot_index == '0), "failed response carries nonzero fields")
   `OHT_ASSERT(a_counter_nonzero, counter_ff != '0, "handle counter reached zero")

endmodule
